// ----- hdl/rosp_pkg.sv -----
package rosp_pkg;

  // angle and sine/cosine scaling (q44)
  localparam int ANG_FRAC = 44;
  localparam int ANG_W    = 48;
  localparam int CF_W     = 50;
  localparam int PROD_W   = 82;
  localparam int ACC_W    = 114;
  localparam int NUM_W    = 81;
  localparam int DIVD_W   = NUM_W - 1 + 32;

  localparam int CORDIC_ITERS = 32;
  localparam int RED_STEPS    = 18;
  localparam int NUM_PROD     = 14;

  localparam logic [63:0] HALF_PI_Q    = 64'h0000_1921_FB54_442D;
  localparam logic [63:0] TWO_PI_Q     = 64'h0000_6487_ED51_10B4;
  localparam logic [63:0] QUARTER_PI_Q = 64'h0000_0C90_FDAA_2217;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q = 48'sd10682906608694;
  localparam logic signed [ANG_W-1:0] ONE_Q = 48'sd1 <<< ANG_FRAC;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic               err;
    logic [31:0]        n;
    logic [31:0]        t;
    logic [63:0]        tau;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } item_t;

  // data that rides along the divider
  typedef struct packed {
    logic                  err;
    logic [2:0]            neg;
    logic [2:0][ACC_W-1:0] acc;
    logic [2:0][31:0]      res;
  } div_side_t;

  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], a[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in q44, series summed in q62 then rounded
  function automatic logic signed [ANG_W-1:0] atan_q(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    acc = '0;
    if (i == 0) begin
      return ANG_W'(QUARTER_PI_Q);
    end
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) acc = acc - term;
        else acc = acc + term;
      end
    end
    acc = (acc + 64'd131072) >> 18;
    return ANG_W'(acc);
  endfunction

  // q60 accumulator to q15.16, round half away from zero, saturate
  function automatic logic [31:0] sat_round(input logic signed [ACC_W-1:0] a);
    logic                      neg;
    logic [ACC_W-1:0]          mag;
    logic [ACC_W-ANG_FRAC-1:0] m;
    logic [31:0]               v;
    neg = a[ACC_W-1];
    mag = neg ? ACC_W'(-a) : ACC_W'(a);
    mag = mag + (ACC_W'(1) << (ANG_FRAC - 1));
    m   = mag[ACC_W-1:ANG_FRAC];
    if (neg) begin
      v = (m > (ACC_W-ANG_FRAC)'(32'h8000_0000)) ? 32'h8000_0000 : m[31:0];
    end else begin
      v = (m > (ACC_W-ANG_FRAC)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m[31:0];
    end
    return neg ? (32'd0 - v) : v;
  endfunction

endpackage

// ----- hdl/rosp_div.sv -----
module rosp_div import rosp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [31:0]            n_i,
  input  logic [2:0][DIVD_W-1:0] dvd_i,
  input  div_side_t              side_i,
  output logic                   valid_o,
  output logic [2:0][DIVD_W-1:0] quot_o,
  output div_side_t              side_o
);

  // restoring division, one quotient bit per stage; dividend bits shift out
  // of the top while quotient bits shift in at the bottom
  logic                   v_q    [DIVD_W];
  logic [31:0]            n_q    [DIVD_W];
  logic [2:0][DIVD_W-1:0] w_q    [DIVD_W];
  logic [2:0][31:0]       rem_q  [DIVD_W];
  div_side_t              side_q [DIVD_W];

  for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
    logic                   v_in;
    logic [31:0]            n_in;
    logic [2:0][DIVD_W-1:0] w_in;
    logic [2:0][31:0]       rem_in;
    div_side_t              side_in;
    logic [2:0][DIVD_W-1:0] w_d;
    logic [2:0][31:0]       rem_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = n_i;
      assign w_in    = dvd_i;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign n_in    = n_q[k-1];
      assign w_in    = w_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      logic [32:0] r2;
      for (int j = 0; j < 3; j++) begin
        r2 = {rem_in[j], w_in[j][DIVD_W-1]};
        if (r2 >= {1'b0, n_in}) begin
          r2       = r2 - {1'b0, n_in};
          w_d[j]   = {w_in[j][DIVD_W-2:0], 1'b1};
        end else begin
          w_d[j]   = {w_in[j][DIVD_W-2:0], 1'b0};
        end
        rem_d[j] = r2[31:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_in;
        w_q[k]    <= w_d;
        rem_q[k]  <= rem_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[DIVD_W-1];
  assign quot_o  = w_q[DIVD_W-1];
  assign side_o  = side_q[DIVD_W-1];

endmodule

// ----- hdl/relative_orbit_state_propagator_core.sv -----
// clohessy-wiltshire relative state propagator. each input word carries a
// relative position/velocity and an interval; the mean motion register sets
// the orbit rate. the pipeline takes one word every cycle while in_stall_o is
// low and returns its result after these stages: the tau = n*t stage, 18
// range-reduction stages (one quotient bit of tau mod 2*pi each), 1 quadrant
// stage, 32 unrolled cordic stages, 7 stages for the fold-back, coefficients,
// products, row sums and numerator magnitudes, 112 stages of the
// bit-per-stage divider that forms the terms divided by n, and 2 stages to
// finish, round and saturate. the divider sets the depth.
// a zero mean motion returns status 1 with all state fields zero. the mean
// motion register may only be written while the pipeline is empty.
module relative_orbit_state_propagator_core import rosp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] interval_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] new_pos_x_o,
  output logic [31:0] new_pos_y_o,
  output logic [31:0] new_pos_z_o,
  output logic [31:0] new_vel_x_o,
  output logic [31:0] new_vel_y_o,
  output logic [31:0] new_vel_z_o,
  output logic        status_o
);

  // product slots: coefficient times state component
  localparam int P_A0_PX  = 0;
  localparam int P_S_PX   = 1;
  localparam int P_C_PZ   = 2;
  localparam int P_NS_PX  = 3;
  localparam int P_C_VX   = 4;
  localparam int P_NO_PX  = 5;
  localparam int P_B4_VY  = 6;
  localparam int P_NS_PZ  = 7;
  localparam int P_C_VZ   = 8;
  localparam int P_S_VX   = 9;
  localparam int P_OM_VY  = 10;
  localparam int P_OM_VX  = 11;
  localparam int P_S_VY   = 12;
  localparam int P_S_VZ   = 13;

  logic [31:0] mean_motion_q;
  logic        en;
  logic        out_valid_q;

  // whole pipeline moves together; the output register is the last stage
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_motion_q <= '0;
    end else if (cfg_we_i) begin
      mean_motion_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // tau = n * t (index 0) and range reduction tau mod 2*pi
  // ---------------------------------------------------------------------
  logic        red_v_q  [RED_STEPS+1];
  item_t       red_it_q [RED_STEPS+1];
  logic [63:0] red_r_q  [RED_STEPS+1];
  item_t       in_item;

  always_comb begin
    in_item.err = (mean_motion_q == '0);
    in_item.n   = mean_motion_q;
    in_item.t   = interval_i;
    in_item.tau = 64'(mean_motion_q) * 64'(interval_i);
    in_item.px  = pos_x_i;
    in_item.py  = pos_y_i;
    in_item.pz  = pos_z_i;
    in_item.vx  = vel_x_i;
    in_item.vy  = vel_y_i;
    in_item.vz  = vel_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_v_q[0] <= 1'b0;
    end else if (en) begin
      red_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_it_q[0] <= in_item;
      red_r_q[0]  <= in_item.tau;
    end
  end

  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    localparam logic [63:0] MOD_K = TWO_PI_Q << (RED_STEPS - 1 - k);
    logic [63:0] r_d;

    assign r_d = (red_r_q[k] >= MOD_K) ? (red_r_q[k] - MOD_K) : red_r_q[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        red_v_q[k+1] <= 1'b0;
      end else if (en) begin
        red_v_q[k+1] <= red_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        red_it_q[k+1] <= red_it_q[k];
        red_r_q[k+1]  <= r_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // quadrant split: 2*pi is exactly four half-pi steps
  // ---------------------------------------------------------------------
  logic              qd_v_q;
  item_t             qd_it_q;
  logic [ANG_W-1:0]  qd_r_q;
  quad_e             qd_quad_q;
  logic [63:0]       qd_r1;
  logic [63:0]       qd_r2;
  logic              qd_hi;
  logic              qd_lo;

  always_comb begin
    qd_hi = red_r_q[RED_STEPS] >= (HALF_PI_Q << 1);
    qd_r1 = qd_hi ? (red_r_q[RED_STEPS] - (HALF_PI_Q << 1)) : red_r_q[RED_STEPS];
    qd_lo = qd_r1 >= HALF_PI_Q;
    qd_r2 = qd_lo ? (qd_r1 - HALF_PI_Q) : qd_r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qd_v_q <= 1'b0;
    end else if (en) begin
      qd_v_q <= red_v_q[RED_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qd_it_q   <= red_it_q[RED_STEPS];
      qd_r_q    <= qd_r2[ANG_W-1:0];
      qd_quad_q <= quad_e'({qd_hi, qd_lo});
    end
  end

  // ---------------------------------------------------------------------
  // cordic, rotation mode, one iteration per stage
  // ---------------------------------------------------------------------
  logic                    cd_v_q    [CORDIC_ITERS];
  item_t                   cd_it_q   [CORDIC_ITERS];
  logic signed [ANG_W-1:0] cd_x_q    [CORDIC_ITERS];
  logic signed [ANG_W-1:0] cd_y_q    [CORDIC_ITERS];
  logic signed [ANG_W-1:0] cd_z_q    [CORDIC_ITERS];
  quad_e                   cd_quad_q [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_q(i);
    logic                    v_in;
    item_t                   it_in;
    logic signed [ANG_W-1:0] x_in;
    logic signed [ANG_W-1:0] y_in;
    logic signed [ANG_W-1:0] z_in;
    quad_e                   quad_in;
    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;

    if (i == 0) begin : g_first
      assign v_in    = qd_v_q;
      assign it_in   = qd_it_q;
      assign x_in    = CORDIC_GAIN_Q;
      assign y_in    = '0;
      assign z_in    = qd_r_q;
      assign quad_in = qd_quad_q;
    end else begin : g_next
      assign v_in    = cd_v_q[i-1];
      assign it_in   = cd_it_q[i-1];
      assign x_in    = cd_x_q[i-1];
      assign y_in    = cd_y_q[i-1];
      assign z_in    = cd_z_q[i-1];
      assign quad_in = cd_quad_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cd_v_q[i] <= 1'b0;
      end else if (en) begin
        cd_v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cd_it_q[i]   <= it_in;
        cd_quad_q[i] <= quad_in;
        if (!z_in[ANG_W-1]) begin
          cd_x_q[i] <= x_in - dx;
          cd_y_q[i] <= y_in + dy;
          cd_z_q[i] <= z_in - ATAN_I;
        end else begin
          cd_x_q[i] <= x_in + dx;
          cd_y_q[i] <= y_in - dy;
          cd_z_q[i] <= z_in + ATAN_I;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // m0: quadrant fold-back, 1 - cos
  // ---------------------------------------------------------------------
  logic                    m0_v_q;
  item_t                   m0_it_q;
  logic signed [ANG_W-1:0] m0_s_q;
  logic signed [ANG_W-1:0] m0_c_q;
  logic signed [ANG_W-1:0] m0_omc_q;
  logic signed [ANG_W-1:0] m0_s_d;
  logic signed [ANG_W-1:0] m0_c_d;
  logic signed [ANG_W-1:0] sf;
  logic signed [ANG_W-1:0] cf;

  assign sf = cd_y_q[CORDIC_ITERS-1];
  assign cf = cd_x_q[CORDIC_ITERS-1];

  always_comb begin
    case (cd_quad_q[CORDIC_ITERS-1])
      QUAD_0: begin m0_s_d = sf;  m0_c_d = cf;  end
      QUAD_1: begin m0_s_d = cf;  m0_c_d = -sf; end
      QUAD_2: begin m0_s_d = -sf; m0_c_d = -cf; end
      QUAD_3: begin m0_s_d = -cf; m0_c_d = sf;  end
      default: begin m0_s_d = sf; m0_c_d = cf;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m0_v_q <= 1'b0;
    end else if (en) begin
      m0_v_q <= cd_v_q[CORDIC_ITERS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_it_q  <= cd_it_q[CORDIC_ITERS-1];
      m0_s_q   <= m0_s_d;
      m0_c_q   <= m0_c_d;
      m0_omc_q <= ONE_Q - m0_c_d;
    end
  end

  // ---------------------------------------------------------------------
  // m1: n*|s| and n*|1-c| as two partial products each, fixed coefficients
  // ---------------------------------------------------------------------
  logic                   m1_v_q;
  item_t                  m1_it_q;
  logic signed [CF_W-1:0] m1_s_q;
  logic signed [CF_W-1:0] m1_c_q;
  logic signed [CF_W-1:0] m1_omc_q;
  logic signed [CF_W-1:0] m1_a0_q;
  logic signed [CF_W-1:0] m1_b4_q;
  logic [55:0]            m1_sp_lo_q;
  logic [55:0]            m1_sp_hi_q;
  logic [55:0]            m1_op_lo_q;
  logic [55:0]            m1_op_hi_q;
  logic                   m1_sneg_q;
  logic                   m1_oneg_q;
  logic [ANG_W-1:0]       s_mag;
  logic [ANG_W-1:0]       o_mag;
  logic signed [CF_W-1:0] c_w;

  assign s_mag = m0_s_q[ANG_W-1] ? ANG_W'(-m0_s_q) : ANG_W'(m0_s_q);
  assign o_mag = m0_omc_q[ANG_W-1] ? ANG_W'(-m0_omc_q) : ANG_W'(m0_omc_q);
  assign c_w   = CF_W'(m0_c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= m0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_it_q    <= m0_it_q;
      m1_s_q     <= CF_W'(m0_s_q);
      m1_c_q     <= c_w;
      m1_omc_q   <= CF_W'(m0_omc_q);
      // 4 - 3c and 4c - 3
      m1_a0_q    <= (CF_W'(ONE_Q) <<< 2) - ((c_w <<< 1) + c_w);
      m1_b4_q    <= (c_w <<< 2) - ((CF_W'(ONE_Q) <<< 1) + CF_W'(ONE_Q));
      m1_sp_lo_q <= 56'(m0_it_q.n) * 56'(s_mag[23:0]);
      m1_sp_hi_q <= 56'(m0_it_q.n) * 56'(s_mag[ANG_W-1:24]);
      m1_op_lo_q <= 56'(m0_it_q.n) * 56'(o_mag[23:0]);
      m1_op_hi_q <= 56'(m0_it_q.n) * 56'(o_mag[ANG_W-1:24]);
      m1_sneg_q  <= m0_s_q[ANG_W-1];
      m1_oneg_q  <= m0_omc_q[ANG_W-1];
    end
  end

  // ---------------------------------------------------------------------
  // m2: round n*s and n*(1-c), build coefficient slots
  // ---------------------------------------------------------------------
  logic                   m2_v_q;
  item_t                  m2_it_q;
  logic signed [CF_W-1:0] m2_coef_q [NUM_PROD];
  logic [79:0]            ns_full;
  logic [79:0]            no_full;
  logic signed [CF_W-1:0] ns_d;
  logic signed [CF_W-1:0] no_d;

  always_comb begin
    ns_full = (80'(m1_sp_hi_q) << 24) + 80'(m1_sp_lo_q) + (80'd1 << 31);
    no_full = (80'(m1_op_hi_q) << 24) + 80'(m1_op_lo_q) + (80'd1 << 31);
    ns_d    = $signed({2'b00, ns_full[79:32]});
    no_d    = $signed({2'b00, no_full[79:32]});
    if (m1_sneg_q) ns_d = -ns_d;
    if (m1_oneg_q) no_d = -no_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_it_q            <= m1_it_q;
      m2_coef_q[P_A0_PX] <= m1_a0_q;
      m2_coef_q[P_S_PX]  <= m1_s_q;
      m2_coef_q[P_C_PZ]  <= m1_c_q;
      m2_coef_q[P_NS_PX] <= ns_d;
      m2_coef_q[P_C_VX]  <= m1_c_q;
      m2_coef_q[P_NO_PX] <= no_d;
      m2_coef_q[P_B4_VY] <= m1_b4_q;
      m2_coef_q[P_NS_PZ] <= ns_d;
      m2_coef_q[P_C_VZ]  <= m1_c_q;
      m2_coef_q[P_S_VX]  <= m1_s_q;
      m2_coef_q[P_OM_VY] <= m1_omc_q;
      m2_coef_q[P_OM_VX] <= m1_omc_q;
      m2_coef_q[P_S_VY]  <= m1_s_q;
      m2_coef_q[P_S_VZ]  <= m1_s_q;
    end
  end

  // ---------------------------------------------------------------------
  // m3: split partial products
  // ---------------------------------------------------------------------
  logic               m3_v_q;
  item_t              m3_it_q;
  logic signed [57:0] m3_plo_q [NUM_PROD];
  logic signed [56:0] m3_phi_q [NUM_PROD];
  logic signed [64:0] m3_tlo_q;
  logic signed [64:0] m3_thi_q;
  logic signed [64:0] m3_tvy_q;
  logic signed [31:0] pval [NUM_PROD];

  always_comb begin
    pval[P_A0_PX] = m2_it_q.px;
    pval[P_S_PX]  = m2_it_q.px;
    pval[P_C_PZ]  = m2_it_q.pz;
    pval[P_NS_PX] = m2_it_q.px;
    pval[P_C_VX]  = m2_it_q.vx;
    pval[P_NO_PX] = m2_it_q.px;
    pval[P_B4_VY] = m2_it_q.vy;
    pval[P_NS_PZ] = m2_it_q.pz;
    pval[P_C_VZ]  = m2_it_q.vz;
    pval[P_S_VX]  = m2_it_q.vx;
    pval[P_OM_VY] = m2_it_q.vy;
    pval[P_OM_VX] = m2_it_q.vx;
    pval[P_S_VY]  = m2_it_q.vy;
    pval[P_S_VZ]  = m2_it_q.vz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (en) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_it_q <= m2_it_q;
      for (int j = 0; j < NUM_PROD; j++) begin
        m3_plo_q[j] <= 58'($signed({1'b0, m2_coef_q[j][24:0]}) * pval[j]);
        m3_phi_q[j] <= 57'($signed(m2_coef_q[j][CF_W-1:25]) * pval[j]);
      end
      m3_tlo_q <= 65'($signed({1'b0, m2_it_q.tau[31:0]}) * m2_it_q.px);
      m3_thi_q <= 65'($signed({1'b0, m2_it_q.tau[63:32]}) * m2_it_q.px);
      m3_tvy_q <= 65'($signed({1'b0, m2_it_q.t}) * m2_it_q.vy);
    end
  end

  // ---------------------------------------------------------------------
  // m4: recombine partial products
  // ---------------------------------------------------------------------
  logic                     m4_v_q;
  item_t                    m4_it_q;
  logic signed [PROD_W-1:0] m4_p_q [NUM_PROD];
  logic signed [ACC_W-1:0]  m4_taupx_q;
  logic signed [64:0]       m4_tvy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m4_v_q <= 1'b0;
    end else if (en) begin
      m4_v_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_it_q <= m3_it_q;
      for (int j = 0; j < NUM_PROD; j++) begin
        m4_p_q[j] <= (PROD_W'(m3_phi_q[j]) <<< 25) + PROD_W'(m3_plo_q[j]);
      end
      m4_taupx_q <= (ACC_W'(m3_thi_q) <<< 32) + ACC_W'(m3_tlo_q);
      m4_tvy_q   <= m3_tvy_q;
    end
  end

  // ---------------------------------------------------------------------
  // m5: row sums without the divided terms, and the divider numerators
  // ---------------------------------------------------------------------
  logic                    m5_v_q;
  logic                    m5_err_q;
  logic [31:0]             m5_n_q;
  logic signed [ACC_W-1:0] m5_row_q [6];
  logic signed [NUM_W-1:0] m5_num_q [3];
  logic signed [ACC_W-1:0] pa [NUM_PROD];
  logic signed [ACC_W-1:0] tvy_a;
  logic signed [ACC_W-1:0] row_d [6];
  logic signed [ACC_W-1:0] num_d [3];

  always_comb begin
    for (int j = 0; j < NUM_PROD; j++) begin
      pa[j] = ACC_W'(m4_p_q[j]);
    end
    tvy_a = ACC_W'(m4_tvy_q);
    row_d[0] = pa[P_A0_PX];
    // y: py + 6 s px - 6 tau px - 3 t vy (times 2^32 for q44 alignment)
    row_d[1] = (ACC_W'(m4_it_q.py) <<< ANG_FRAC)
             + ((pa[P_S_PX] <<< 2) + (pa[P_S_PX] <<< 1))
             - ((m4_taupx_q <<< 2) + (m4_taupx_q <<< 1))
             - (((tvy_a <<< 1) + tvy_a) <<< 32);
    row_d[2] = pa[P_C_PZ];
    row_d[3] = ((pa[P_NS_PX] <<< 1) + pa[P_NS_PX]) + pa[P_C_VX] + (pa[P_S_VY] <<< 1);
    row_d[4] = pa[P_B4_VY] - ((pa[P_NO_PX] <<< 2) + (pa[P_NO_PX] <<< 1))
             - (pa[P_S_VX] <<< 1);
    row_d[5] = pa[P_C_VZ] - pa[P_NS_PZ];
    num_d[0] = pa[P_S_VX] + (pa[P_OM_VY] <<< 1);
    num_d[1] = (pa[P_S_VY] <<< 2) - (pa[P_OM_VX] <<< 1);
    num_d[2] = pa[P_S_VZ];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m5_v_q <= 1'b0;
    end else if (en) begin
      m5_v_q <= m4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m5_err_q <= m4_it_q.err;
      m5_n_q   <= m4_it_q.n;
      for (int j = 0; j < 6; j++) begin
        m5_row_q[j] <= row_d[j];
      end
      for (int j = 0; j < 3; j++) begin
        m5_num_q[j] <= num_d[j][NUM_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // m6: finish rows without divided terms, take numerator magnitudes
  // ---------------------------------------------------------------------
  logic                   m6_v_q;
  logic [31:0]            m6_n_q;
  logic [2:0][DIVD_W-1:0] m6_dvd_q;
  div_side_t              m6_side_q;
  logic [2:0][DIVD_W-1:0] dvd_d;
  div_side_t              side_d;
  logic [NUM_W-1:0]       nmag;

  always_comb begin
    side_d.err = m5_err_q;
    for (int j = 0; j < 3; j++) begin
      side_d.neg[j] = m5_num_q[j][NUM_W-1];
      nmag          = side_d.neg[j] ? NUM_W'(-m5_num_q[j]) : NUM_W'(m5_num_q[j]);
      dvd_d[j]      = {nmag[NUM_W-2:0], 32'd0};
      side_d.acc[j] = m5_row_q[j];
      side_d.res[j] = sat_round(m5_row_q[j+3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m6_v_q <= 1'b0;
    end else if (en) begin
      m6_v_q <= m5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m6_n_q    <= m5_n_q;
      m6_dvd_q  <= dvd_d;
      m6_side_q <= side_d;
    end
  end

  // ---------------------------------------------------------------------
  // division by n, truncated toward zero
  // ---------------------------------------------------------------------
  logic                   dv_v;
  logic [2:0][DIVD_W-1:0] dv_quot;
  div_side_t              dv_side;

  rosp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m6_v_q),
    .n_i     (m6_n_q),
    .dvd_i   (m6_dvd_q),
    .side_i  (m6_side_q),
    .valid_o (dv_v),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------------
  // f1: add quotients into rows x, y, z
  // ---------------------------------------------------------------------
  logic                    f1_v_q;
  logic                    f1_err_q;
  logic signed [ACC_W-1:0] f1_acc_q [3];
  logic [2:0][31:0]        f1_res_q;
  logic signed [ACC_W-1:0] qa;
  logic signed [ACC_W-1:0] f1_acc_d [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qa          = $signed(ACC_W'(dv_quot[j]));
      f1_acc_d[j] = dv_side.neg[j] ? ($signed(dv_side.acc[j]) - qa)
                                   : ($signed(dv_side.acc[j]) + qa);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_err_q <= dv_side.err;
      f1_res_q <= dv_side.res;
      for (int j = 0; j < 3; j++) begin
        f1_acc_q[j] <= f1_acc_d[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register: round, saturate, zero-motion override
  // ---------------------------------------------------------------------
  logic [31:0] out_px_q;
  logic [31:0] out_py_q;
  logic [31:0] out_pz_q;
  logic [31:0] out_vx_q;
  logic [31:0] out_vy_q;
  logic [31:0] out_vz_q;
  logic        out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_err_q <= f1_err_q;
      out_px_q  <= f1_err_q ? '0 : sat_round(f1_acc_q[0]);
      out_py_q  <= f1_err_q ? '0 : sat_round(f1_acc_q[1]);
      out_pz_q  <= f1_err_q ? '0 : sat_round(f1_acc_q[2]);
      out_vx_q  <= f1_err_q ? '0 : f1_res_q[0];
      out_vy_q  <= f1_err_q ? '0 : f1_res_q[1];
      out_vz_q  <= f1_err_q ? '0 : f1_res_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_pos_x_o = out_px_q;
  assign new_pos_y_o = out_py_q;
  assign new_pos_z_o = out_pz_q;
  assign new_vel_x_o = out_vx_q;
  assign new_vel_y_o = out_vy_q;
  assign new_vel_z_o = out_vz_q;
  assign status_o    = out_err_q;

endmodule
